// ===== rtl/wlsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the wear-leveling slot remapper.
package wlsr_pkg;

   localparam int HEAT_W = 16;
   localparam int COOL_W = 9;
   localparam int SLOT_OUT_W = 4;
   localparam int ID_IN_W = 3;
   localparam int PROD_W = HEAT_W + COOL_W;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [HEAT_W-1:0] HEAT_LIMIT_RESET = 16'd63936;
   localparam logic [COOL_W-1:0] COOL_FACTOR_RESET = 9'd77;
   localparam logic [HEAT_W-1:0] HEAT_MAX = 16'hFFFF;

   localparam logic REG_HEAT_LIMIT = 1'b0;
   localparam logic REG_COOL_FACTOR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE,
      ST_OLD_MUL,
      ST_OLD_WR,
      ST_NEW_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic scan_start;
      logic scan_rd;
      logic old_rd;
      logic mul_en;
      logic old_wr;
      logic new_wr;
      logic rsp_valid;
   } ctrl_type;

endpackage

// ===== rtl/wlsr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wlsr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/wlsr_scan.sv =====
`timescale 1ns / 1ps
// Shared compare unit that tracks the coldest qualifying free slot over a scan.
module wlsr_scan #(
   parameter int SLOT_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [wlsr_pkg::HEAT_W-1:0] limit,
   input  logic                      cmp_en,
   input  logic                      cand_free,
   input  logic [wlsr_pkg::HEAT_W-1:0] cand_heat,
   input  logic [SLOT_W-1:0]         cand_idx,
   output logic [SLOT_W-1:0]         best_idx,
   output logic                      found
);
   import wlsr_pkg::*;

   logic [HEAT_W-1:0] best_heat_ff, best_heat_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic              found_ff, found_in;
   logic              take;

   assign take = cmp_en && cand_free && (cand_heat < best_heat_ff);

   always_comb begin
      best_heat_in = best_heat_ff;
      best_idx_in = best_idx_ff;
      found_in = found_ff;
      if (start) begin
         best_heat_in = limit;
         best_idx_in = '0;
         found_in = 1'b0;
      end else if (take) begin
         best_heat_in = cand_heat;
         best_idx_in = cand_idx;
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_heat_ff <= best_heat_in;
      best_idx_ff <= best_idx_in;
   end

   assign best_idx = best_idx_ff;
   assign found = found_ff;

endmodule

// ===== rtl/wlsr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps one remap request through scan, then cooling and update as needed.
module wlsr_ctrl #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          rsp_ready,
   input  logic                          found,
   input  logic                          mapped,
   output wlsr_pkg::ctrl_type            ctrl,
   output logic [$clog2(NUM_SLOTS)-1:0]  cnt
);
   import wlsr_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (found && mapped) begin
               state_in = ST_OLD_MUL;
            end else if (found) begin
               state_in = ST_NEW_WR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_OLD_MUL: state_in = ST_OLD_WR;
         ST_OLD_WR: state_in = ST_NEW_WR;
         ST_NEW_WR: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.scan_start = 1'b1;
            cnt_in = '0;
         end
         ST_SCAN: begin
            ctrl.scan_rd = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_LAST: ;
         ST_DECIDE: ctrl.old_rd = found && mapped;
         ST_OLD_MUL: ctrl.mul_en = 1'b1;
         ST_OLD_WR: ctrl.old_wr = 1'b1;
         ST_NEW_WR: ctrl.new_wr = 1'b1;
         ST_RESP: ctrl.rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   assign cnt = cnt_ff;

endmodule

// ===== rtl/wear_level_slot_remap.sv =====
`timescale 1ns / 1ps
// Wear-leveling remapper: moves a logical id to the coldest free slot below a heat limit.
// After the scan, a mapped id has its old slot cooled and rewritten before the new slot is written;
// an unmapped id gets only the new-slot write, and when no slot qualifies the result follows directly.
// One word at a time: the next word can be taken in the cycle after the result is taken.
// The serial heat scan reads one slot per cycle through one RAM read port.
// Synchronous reset restores the linear map, the free marks, zero heats and register defaults.
module wear_level_slot_remap #(
   parameter int NUM_SLOTS = 16,
   parameter int NUM_IDS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wlsr_pkg::ID_IN_W-1:0]      req_logical_id,
   input  logic [wlsr_pkg::HEAT_W-1:0]       req_logical_heat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_status,
   output logic                              rsp_was_mapped,
   output logic [wlsr_pkg::SLOT_OUT_W-1:0]   rsp_old_slot,
   output logic [wlsr_pkg::SLOT_OUT_W-1:0]   rsp_new_slot,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wlsr_pkg::CSR_AW-1:0]       paddr,
   input  logic [wlsr_pkg::CSR_DW-1:0]       pwdata,
   output logic [wlsr_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);
   import wlsr_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int ID_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

   ctrl_type          ctrl;
   logic [SLOT_W-1:0] cnt;
   logic              accept;

   logic [HEAT_W-1:0] heat_limit_ff;
   logic [COOL_W-1:0] cool_factor_ff;
   logic              csr_wr;

   logic [SLOT_W-1:0] id_slot_ff [NUM_IDS];
   logic              id_mapped_ff [NUM_IDS];
   logic [ID_W-1:0]   slot_owner_ff [NUM_SLOTS];
   logic              slot_free_ff [NUM_SLOTS];
   logic              heat_vld_ff [NUM_SLOTS];

   logic [ID_W-1:0]   id_idx;
   logic              id_ok;
   logic              in_mapped;

   logic [ID_W-1:0]   id_ff;
   logic [HEAT_W-1:0] heat_ff;
   logic              id_ok_ff;
   logic              mapped_ff;
   logic [SLOT_W-1:0] old_ff;

   logic [SLOT_W-1:0] raddr;
   logic [SLOT_W-1:0] waddr;
   logic [HEAT_W-1:0] wdata;
   logic              we;
   logic [HEAT_W-1:0] rdata;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              rd_hv_ff;
   logic [HEAT_W-1:0] cand_heat;

   logic [PROD_W-1:0] prod_ff;
   logic [HEAT_W-1:0] cooled;

   logic [SLOT_W-1:0] best_idx;
   logic              scan_found;
   logic              found_eff;

   assign accept = req_valid && ctrl.req_ready;
   assign req_ready = ctrl.req_ready;

   // Configuration registers.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_limit_ff <= HEAT_LIMIT_RESET;
         cool_factor_ff <= COOL_FACTOR_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_HEAT_LIMIT) begin
            heat_limit_ff <= pwdata[HEAT_W-1:0];
         end else begin
            cool_factor_ff <= pwdata[COOL_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_HEAT_LIMIT:  prdata = CSR_DW'(heat_limit_ff);
         REG_COOL_FACTOR: prdata = CSR_DW'(cool_factor_ff);
         default:         prdata = '0;
      endcase
   end

   // Request capture.
   assign id_idx = ID_W'(req_logical_id);
   assign id_ok = 32'(req_logical_id) < NUM_IDS;
   assign in_mapped = id_ok && id_mapped_ff[id_idx];

   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff <= id_idx;
         heat_ff <= req_logical_heat;
         id_ok_ff <= id_ok;
         mapped_ff <= in_mapped;
         old_ff <= in_mapped ? id_slot_ff[id_idx] : '0;
      end
   end

   // Heat store and scan read pipeline.
   assign raddr = ctrl.old_rd ? old_ff : cnt;
   assign we = ctrl.old_wr || ctrl.new_wr;
   assign waddr = ctrl.old_wr ? old_ff : best_idx;
   assign wdata = ctrl.old_wr ? cooled : heat_ff;

   wlsr_ram #(
      .WIDTH(HEAT_W),
      .DEPTH(NUM_SLOTS)
   ) u_heat_ram (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt;
      rd_hv_ff <= heat_vld_ff[raddr];
   end

   assign cand_heat = rd_hv_ff ? rdata : '0;

   wlsr_scan #(
      .SLOT_W(SLOT_W)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .start(ctrl.scan_start),
      .limit(heat_limit_ff),
      .cmp_en(rd_vld_ff),
      .cand_free(slot_free_ff[rd_idx_ff]),
      .cand_heat(cand_heat),
      .cand_idx(rd_idx_ff),
      .best_idx(best_idx),
      .found(scan_found)
   );

   assign found_eff = scan_found && id_ok_ff;

   wlsr_ctrl #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .rsp_ready(rsp_ready),
      .found(found_eff),
      .mapped(mapped_ff),
      .ctrl(ctrl),
      .cnt(cnt)
   );

   // Cooling of the vacated slot.
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= PROD_W'(cand_heat) * PROD_W'(cool_factor_ff);
      end
   end

   assign cooled = prod_ff[PROD_W-1] ? HEAT_MAX : prod_ff[PROD_W-2:COOL_W-1];

   // Map state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_IDS; i++) begin
            id_mapped_ff[i] <= (i < NUM_SLOTS);
            id_slot_ff[i] <= (i < NUM_SLOTS) ? SLOT_W'(i) : '0;
         end
         for (int j = 0; j < NUM_SLOTS; j++) begin
            slot_owner_ff[j] <= (j < NUM_IDS) ? ID_W'(j) : '0;
            slot_free_ff[j] <= !(j < NUM_IDS);
            heat_vld_ff[j] <= 1'b0;
         end
      end else begin
         if (we) begin
            heat_vld_ff[waddr] <= 1'b1;
         end
         if (ctrl.old_wr) begin
            slot_free_ff[old_ff] <= 1'b1;
            slot_owner_ff[old_ff] <= '0;
         end
         if (ctrl.new_wr) begin
            slot_free_ff[best_idx] <= 1'b0;
            slot_owner_ff[best_idx] <= id_ff;
            id_slot_ff[id_ff] <= best_idx;
            id_mapped_ff[id_ff] <= 1'b1;
         end
      end
   end

   // Result word.
   assign rsp_valid = ctrl.rsp_valid;
   assign rsp_status = !found_eff;
   assign rsp_was_mapped = mapped_ff;
   assign rsp_old_slot = SLOT_OUT_W'(old_ff);
   assign rsp_new_slot = found_eff ? SLOT_OUT_W'(best_idx) : '0;

`ifndef NO_ASSERTIONS
   a_busy_while_responding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result word is pending");

   a_new_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.new_wr |-> slot_free_ff[best_idx])
      else $error("chosen slot was not free");

   a_owner_consistent: assert property (@(posedge clock) disable iff (reset)
      (accept && in_mapped) |->
         (slot_owner_ff[id_slot_ff[id_idx]] == id_idx && !slot_free_ff[id_slot_ff[id_idx]]))
      else $error("forward and reverse maps disagree");

   a_old_write_needs_mapping: assert property (@(posedge clock) disable iff (reset)
      ctrl.old_wr |-> (mapped_ff && found_eff && old_ff != best_idx))
      else $error("cooling write without a valid old slot");
`endif

endmodule
